[hw/rtl/ngca_pkg.sv]
package ngca_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int THR_W               = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd20;
  localparam int HALF_WINDOW_DEFAULT = 5;
  // Depth of the job queue between front and back; a power of two is not required.
  localparam int QUEUE_DEPTH         = 4;
  // Quotient bits resolved per clock in the divider.
  localparam int DIV_STEP            = 4;

endpackage

[hw/rtl/ngca_front.sv]
module ngca_front import ngca_pkg::*; #(
  parameter int HALF_WINDOW = HALF_WINDOW_DEFAULT,
  parameter int SUM_W       = SAMPLE_W + $clog2(2 * HALF_WINDOW + 1),
  parameter int CNT_W       = $clog2(2 * HALF_WINDOW + 2)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [THR_W-1:0]        gate_threshold,
  input  logic                    push,
  output logic                    full,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                    block_end,
  output logic                    job_push,
  input  logic                    job_full,
  output logic signed [SUM_W-1:0] job_sum,
  output logic [CNT_W-1:0]        job_cnt,
  output logic                    job_last
);

  localparam int DEPTH = 2 * HALF_WINDOW + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int K_W   = $clog2(HALF_WINDOW + 1);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                      state;
  logic [THR_W-1:0]          thr;
  logic signed [SAMPLE_W-1:0] hist [DEPTH];
  logic signed [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]          pos;
  logic [K_W-1:0]            flush_k;
  logic [IDX_W-1:0]          flush_top;
  logic signed [SUM_W-1:0]   flush_sum;

  logic                      accept;
  logic signed [SAMPLE_W:0]  s_ext;
  logic [SAMPLE_W:0]         mag;
  logic signed [SAMPLE_W-1:0] gated;
  logic signed [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]          pos_next;
  logic [CNT_W-1:0]          reach;
  logic                      emit_ok;

  assign full   = (state == ST_FLUSH) || job_full;
  assign accept = push && !full;

  assign s_ext = (SAMPLE_W + 1)'(sample_in);
  assign mag   = sample_in[SAMPLE_W-1] ? -s_ext : s_ext;
  assign gated = (mag < (SAMPLE_W + 1)'(thr)) ? '0 : sample_in;

  // The oldest held sample leaves the window once the history is full.
  always_comb begin
    sum_next = sum + SUM_W'(gated);
    if (pos == CNT_W'(DEPTH)) begin
      sum_next = sum_next - SUM_W'(hist[DEPTH-1]);
    end
  end

  assign pos_next = (pos == CNT_W'(DEPTH)) ? pos : pos + 1'b1;

  // A flush result may go out once its window no longer reaches past the
  // current top entry; otherwise the top entry is dropped from the sum first.
  assign reach   = CNT_W'(flush_k) + CNT_W'(HALF_WINDOW - 1);
  assign emit_ok = CNT_W'(flush_top) <= reach;

  always_comb begin
    job_push = 1'b0;
    job_sum  = sum_next;
    job_cnt  = pos_next;
    job_last = 1'b0;
    unique case (state)
      ST_RUN: begin
        job_push = accept && (pos_next > CNT_W'(HALF_WINDOW));
      end
      ST_FLUSH: begin
        job_push = emit_ok && !job_full;
        job_sum  = flush_sum;
        job_cnt  = CNT_W'(flush_top) + 1'b1;
        job_last = (flush_k == K_W'(1));
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= gate_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= gated;
      for (int i = 1; i < DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      sum   <= '0;
      pos   <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (accept) begin
            if (block_end) begin
              state <= ST_FLUSH;
              sum   <= '0;
              pos   <= '0;
            end else begin
              sum <= sum_next;
              pos <= pos_next;
            end
          end
        end
        ST_FLUSH: begin
          if (job_push && flush_k == K_W'(1)) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      if (accept && block_end) begin
        flush_k   <= (pos_next < CNT_W'(HALF_WINDOW)) ? K_W'(pos_next) : K_W'(HALF_WINDOW);
        flush_top <= IDX_W'(pos_next - 1'b1);
        flush_sum <= sum_next;
      end
    end else if (!emit_ok) begin
      flush_sum <= flush_sum - SUM_W'(hist[flush_top]);
      flush_top <= flush_top - 1'b1;
    end else if (job_push) begin
      flush_k <= flush_k - 1'b1;
    end
  end

endmodule

[hw/rtl/ngca_queue.sv]
module ngca_queue import ngca_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              q_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/ngca_back.sv]
module ngca_back import ngca_pkg::*; #(
  parameter int SUM_W = SAMPLE_W + $clog2(2 * HALF_WINDOW_DEFAULT + 1),
  parameter int CNT_W = $clog2(2 * HALF_WINDOW_DEFAULT + 2)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_empty,
  output logic                    job_pop,
  input  logic signed [SUM_W-1:0] job_sum,
  input  logic [CNT_W-1:0]        job_cnt,
  input  logic                    job_last,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [SAMPLE_W-1:0] smoothed_out,
  output logic                    result_last
);

  localparam int MAG_W  = SUM_W - 1;
  localparam int NCYC   = (MAG_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W  = NCYC * DIV_STEP;
  localparam int ITER_W = $clog2(NCYC + 1);

  logic                busy;
  logic                done;
  logic [ITER_W-1:0]   iter;
  logic [PAD_W-1:0]    quo;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    divisor;
  logic                neg;
  logic                last;
  logic                out_valid;

  logic                start;
  logic                load_out;
  logic [SUM_W-1:0]    mag;
  logic [PAD_W-1:0]    quo_next;
  logic [CNT_W-1:0]    rem_next;
  logic [CNT_W:0]      trial;
  logic [SAMPLE_W:0]   q_abs;
  logic [SAMPLE_W:0]   q_signed;

  assign start    = !busy && !done && !job_empty;
  assign job_pop  = start;
  assign empty    = !out_valid;
  assign load_out = done && (!out_valid || pop);
  assign mag      = job_sum[SUM_W-1] ? -job_sum : job_sum;

  // Restoring division, a few quotient bits per clock.
  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {rem_next, quo_next[PAD_W-1]};
      quo_next = {quo_next[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = CNT_W'(trial - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = CNT_W'(trial);
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign q_abs    = quo[SAMPLE_W:0];
  assign q_signed = neg ? -q_abs : q_abs;

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= PAD_W'(mag[MAG_W-1:0]);
      rem     <= '0;
      divisor <= job_cnt;
      neg     <= job_sum[SUM_W-1];
      last    <= job_last;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(NCYC);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (load_out) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      smoothed_out <= q_signed[SAMPLE_W-1:0];
      result_last  <= last;
    end
  end

endmodule

[hw/rtl/noise_gate_centered_average.sv]
// Channel   Ports                              Handshake
// config    cfg_we, gate_threshold             written when cfg_we is high
// samples   sample_in, block_end               taken when push && !full
// results   smoothed_out, result_last          taken when pop && !empty
//
// A sample is taken when the job queue has room; samples are
// refused while the flush results of a finished block are being queued.
// Each result is started, passes through the shared divider and is then
// loaded into the output; the divider takes a new job only once the
// previous result has left it.
// Reset clears the counters, the queue and the output valid flag; the threshold reads 20.
module noise_gate_centered_average import ngca_pkg::*; #(
  parameter int HALF_WINDOW = HALF_WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [THR_W-1:0]           gate_threshold,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [SAMPLE_W-1:0] smoothed_out,
  output logic                       result_last
);

  localparam int DEPTH  = 2 * HALF_WINDOW + 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int JOB_W  = SUM_W + CNT_W + 1;

  logic                    f_push;
  logic                    q_full;
  logic                    q_empty;
  logic                    b_pop;
  logic signed [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0]        f_cnt;
  logic                    f_last;
  logic [JOB_W-1:0]        q_data;

  ngca_front #(
    .HALF_WINDOW (HALF_WINDOW),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .gate_threshold (gate_threshold),
    .push           (push),
    .full           (full),
    .sample_in      (sample_in),
    .block_end      (block_end),
    .job_push       (f_push),
    .job_full       (q_full),
    .job_sum        (f_sum),
    .job_cnt        (f_cnt),
    .job_last       (f_last)
  );

  ngca_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data ({f_sum, f_cnt, f_last}),
    .q_full  (q_full),
    .rd_en   (b_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  ngca_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (q_empty),
    .job_pop      (b_pop),
    .job_sum      (q_data[JOB_W-1 -: SUM_W]),
    .job_cnt      (q_data[CNT_W:1]),
    .job_last     (q_data[0]),
    .empty        (empty),
    .pop          (pop),
    .smoothed_out (smoothed_out),
    .result_last  (result_last)
  );

endmodule

[hw/rtl/ngca_checker.sv]
module ngca_checker import ngca_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input logic                       block_end,
  input logic                       pop,
  input logic                       empty,
  input logic signed [SAMPLE_W-1:0] smoothed_out,
  input logic                       result_last
);

  // After reset nothing is waiting and the input side is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input side not open after reset");

  // The end of a block always starts a flush, during which input is held off.
  a_flush_holds: assert property (@(posedge clk) disable iff (rst)
    (push && !full && block_end) |=> full)
    else $error("input taken while a block is flushing");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(smoothed_out) && $stable(result_last)))
    else $error("waiting result changed before it was taken");

endmodule

bind noise_gate_centered_average ngca_checker u_ngca_checker (.*);
